// ----- src/wcpl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Wheel current power limiter package
// Shared widths, register codes, queue entry types and the buffer factor table.
// ----------------------------------------------------------------------------
package wcpl_pkg;

   localparam int WHEEL_COUNT_DEF = 4;
   localparam int SPEED_W         = 16;
   localparam int MAG_W           = 16;
   localparam int DEN_W           = 19;   // covers the error sum of up to eight wheels
   localparam int POWER_W         = 16;
   localparam int LIMIT_W         = 15;
   localparam int ESL_W           = 18;
   localparam int SCALE_W         = 17;
   localparam int FACTOR_W        = 17;
   localparam int PROD_W          = MAG_W + SCALE_W;
   localparam int WIDE_W          = PROD_W + FACTOR_W;
   localparam int DVD_W           = DEN_W + 16;
   localparam int QUOT_W          = 16;
   localparam int QUEUE_DEPTH     = 2;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 32;

   localparam logic [POWER_W-1:0] POWER_THRESHOLD_RST = 16'd9600;
   localparam logic [LIMIT_W-1:0] OVERLOAD_LIMIT_RST  = 15'd4096;
   localparam logic [ESL_W-1:0]   ERROR_SUM_LIMIT_RST = 18'd16000;
   localparam logic [SCALE_W-1:0] OUTPUT_SCALE_RST    = 17'd61536;

   localparam logic [SPEED_W-1:0] SAT_POS = 16'h7fff;
   localparam logic [SPEED_W-1:0] SAT_NEG = 16'h8000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_POWER_THRESHOLD = 2'd0,
      CSR_OVERLOAD_LIMIT  = 2'd1,
      CSR_ERROR_SUM_LIMIT = 2'd2,
      CSR_OUTPUT_SCALE    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [POWER_W-1:0] power_threshold;
      logic [LIMIT_W-1:0] limit;
      logic [ESL_W-1:0]   error_sum_limit;
      logic [SCALE_W-1:0] output_scale;
   } cfg_type;

   typedef struct packed {
      logic               neg;
      logic [MAG_W-1:0]   mag;
      logic [SPEED_W-1:0] target;
   } lane_type;

   typedef struct packed {
      logic                over;
      logic                clip;
      logic                zero;
      logic [SCALE_W-1:0]  mulb;
      logic [DEN_W-1:0]    den;
      logic [FACTOR_W-1:0] factor;
   } head_type;

   typedef struct packed {
      logic idle;
   } back_status_type;

   // Q1.16 gain chosen by remaining buffer energy
   function automatic logic [FACTOR_W-1:0] buffer_factor(input logic [POWER_W-1:0] b);
      logic [FACTOR_W-1:0] f;
      f = 17'd65536;
      if (b >= 16'd40 && b < 16'd50)      f = 17'd58982;
      else if (b >= 16'd35 && b < 16'd40) f = 17'd49152;
      else if (b >= 16'd30 && b < 16'd35) f = 17'd32768;
      else if (b >= 16'd20 && b < 16'd30) f = 17'd16384;
      else if (b >= 16'd10 && b < 16'd20) f = 17'd8192;
      else if (b >= 16'd1 && b < 16'd10)  f = 17'd3277;
      return f;
   endfunction

endpackage
`default_nettype wire

// ----- src/wheel_current_power_limiter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Wheel current power limiter
// Scales wheel targets over power when the peak exceeds the limit, otherwise spreads a gain-limited current.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one item per transfer: wheel targets, measured speeds, chassis
//            power and buffer energy packed in req_tdata.
//   rsp_*  : one result per item: currents and limited targets in rsp_tdata,
//            currents_valid in rsp_tuser.
//   csr_*  : register writes (index, data), always ready; write only while idle.
// Back end: take, multiply and scale steps, then the 16-step restoring divider
//   (one quotient bit per cycle, one lane per wheel), then the output step;
//   it takes a new item from the queue only when idle.
// The front end classifies an item in the accepting cycle and writes it to a
// two-entry queue, so new items are taken while the divider works.
// Reset clears the queue, the back end and the output register and loads the
// default registers. A stalled receiver holds the result in the output
// register; the back end finishes the next item and waits, the queue fills,
// then req_tready drops.
// ----------------------------------------------------------------------------
module wheel_current_power_limiter
   import wcpl_pkg::*;
#(
   parameter int WHEEL_COUNT = WHEEL_COUNT_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // target_speed_0.., measured_speed_0.., power_draw, energy_left
   input  wire logic [(2*WHEEL_COUNT+2)*SPEED_W-1:0]  req_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // current_0.., limited_target_0..
   output logic [2*WHEEL_COUNT*SPEED_W-1:0]           rsp_tdata,
   // currents_valid
   output logic                                       rsp_tuser,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]                csr_index,
   input  wire logic [CSR_DATA_W-1:0]                 csr_data
);

   localparam int ENTRY_W = $bits(head_type) + WHEEL_COUNT * $bits(lane_type);

   cfg_type                    cfg_ff, cfg_in;
   head_type                   f_head, q_head;
   lane_type [WHEEL_COUNT-1:0] f_lanes, q_lanes;
   logic                       q_full, q_valid, q_ready;
   back_status_type            back_status;

   assign csr_ready  = 1'b1;
   assign req_tready = !q_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_POWER_THRESHOLD: cfg_in.power_threshold = csr_data[POWER_W-1:0];
            CSR_OVERLOAD_LIMIT:  cfg_in.limit           = csr_data[LIMIT_W-1:0];
            CSR_ERROR_SUM_LIMIT: cfg_in.error_sum_limit = csr_data[ESL_W-1:0];
            CSR_OUTPUT_SCALE:    cfg_in.output_scale    = csr_data[SCALE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.power_threshold <= POWER_THRESHOLD_RST;
         cfg_ff.limit           <= OVERLOAD_LIMIT_RST;
         cfg_ff.error_sum_limit <= ERROR_SUM_LIMIT_RST;
         cfg_ff.output_scale    <= OUTPUT_SCALE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wcpl_front #(.WHEEL_COUNT(WHEEL_COUNT)) u_front (
      .cfg      (cfg_ff),
      .req_data (req_tdata),
      .head     (f_head),
      .lanes    (f_lanes)
   );

   wcpl_queue #(.DATA_W(ENTRY_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_data  ({f_head, f_lanes}),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   ({q_head, q_lanes})
   );

   wcpl_back #(.WHEEL_COUNT(WHEEL_COUNT)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_head     (q_head),
      .q_lanes    (q_lanes),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .status     (back_status)
   );

   // over-power results carry zero currents
   a_over_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[WHEEL_COUNT*SPEED_W-1:0] == '0)
      else $error("over-power result with nonzero currents");

   // an idle back end takes a waiting queue entry at once
   a_back_pops: assert property (@(posedge clock) disable iff (reset)
      q_valid && back_status.idle |=> !back_status.idle)
      else $error("back end ignored a queued item");

endmodule
`default_nettype wire

// ----- src/wcpl_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Wheel current power limiter front end
// Splits an item into wheel errors, magnitudes, sum and peak, picks the branch.
// ----------------------------------------------------------------------------
module wcpl_front
   import wcpl_pkg::*;
#(
   parameter int WHEEL_COUNT = WHEEL_COUNT_DEF
) (
   input  wire cfg_type                               cfg,
   input  wire logic [(2*WHEEL_COUNT+2)*SPEED_W-1:0]  req_data,
   output head_type                                   head,
   output lane_type [WHEEL_COUNT-1:0]                 lanes
);

   always_comb begin
      logic signed [SPEED_W-1:0] t;
      logic signed [SPEED_W-1:0] ms;
      logic signed [SPEED_W:0]   err;
      logic [MAG_W-1:0]          tmag;
      logic [MAG_W-1:0]          emag;
      logic [DEN_W-1:0]          sum;
      logic [MAG_W-1:0]          peak;
      logic [POWER_W-1:0]        power;
      logic [POWER_W-1:0]        energy;
      logic                      over;
      sum    = '0;
      peak   = '0;
      power  = req_data[2*WHEEL_COUNT*SPEED_W +: POWER_W];
      energy = req_data[(2*WHEEL_COUNT+1)*SPEED_W +: POWER_W];
      over   = power > cfg.power_threshold;
      for (int i = 0; i < WHEEL_COUNT; i++) begin
         t    = req_data[i*SPEED_W +: SPEED_W];
         ms   = req_data[(WHEEL_COUNT+i)*SPEED_W +: SPEED_W];
         err  = {t[SPEED_W-1], t} - {ms[SPEED_W-1], ms};
         tmag = t[SPEED_W-1] ? MAG_W'(-t) : MAG_W'(t);
         emag = err[SPEED_W] ? MAG_W'(-err) : MAG_W'(err);
         sum  = sum + DEN_W'(emag);
         if (tmag > peak) peak = tmag;
         lanes[i].neg    = over ? t[SPEED_W-1] : err[SPEED_W];
         lanes[i].mag    = over ? tmag : emag;
         lanes[i].target = t;
      end
      head.over   = over;
      head.clip   = peak > MAG_W'(cfg.limit);
      head.zero   = sum == '0;
      head.mulb   = over ? SCALE_W'(cfg.limit) : cfg.output_scale;
      head.den    = over ? DEN_W'(peak)
                  : ((sum > DEN_W'(cfg.error_sum_limit)) ? sum
                                                         : DEN_W'(cfg.error_sum_limit));
      head.factor = buffer_factor(energy);
   end

endmodule
`default_nettype wire

// ----- src/wcpl_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Wheel current power limiter queue
// Short FIFO that decouples the front end from the divider back end.
// ----------------------------------------------------------------------------
module wcpl_queue
   import wcpl_pkg::*;
#(
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire logic [DATA_W-1:0] push_data,
   output logic                   full,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output logic [DATA_W-1:0]      pop_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = count_ff == CNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

// ----- src/wcpl_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Wheel current power limiter back end
// Per-wheel multiply, scale and restoring divide, then saturation and output.
// ----------------------------------------------------------------------------
module wcpl_back
   import wcpl_pkg::*;
#(
   parameter int WHEEL_COUNT = WHEEL_COUNT_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               q_valid,
   output logic                                    q_ready,
   input  wire head_type                           q_head,
   input  wire lane_type [WHEEL_COUNT-1:0]         q_lanes,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [2*WHEEL_COUNT*SPEED_W-1:0]        rsp_tdata,
   output logic                                    rsp_tuser,
   output back_status_type                         status
);

   localparam int STEP_W = $clog2(QUOT_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUOT_W-1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MUL   = 5'b00010,
      ST_SCALE = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_FIN   = 5'b10000
   } state_type;

   state_type                       state_ff, state_in;
   head_type                        head_ff, head_in;
   lane_type [WHEEL_COUNT-1:0]      lanes_ff, lanes_in;
   logic [PROD_W-1:0]               prod_ff [WHEEL_COUNT];
   logic [PROD_W-1:0]               prod_in [WHEEL_COUNT];
   logic [DVD_W-1:0]                dvd_ff [WHEEL_COUNT];
   logic [DVD_W-1:0]                dvd_in [WHEEL_COUNT];
   logic [QUOT_W-1:0]               quot_ff [WHEEL_COUNT];
   logic [QUOT_W-1:0]               quot_in [WHEEL_COUNT];
   logic [WHEEL_COUNT-1:0]          ovf_ff, ovf_in;
   logic [DVD_W-1:0]                vs_ff, vs_in;
   logic [STEP_W-1:0]               step_ff, step_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [2*WHEEL_COUNT*SPEED_W-1:0] rsp_data_ff, rsp_data_in;
   logic                            rsp_user_ff, rsp_user_in;

   assign q_ready     = state_ff == ST_IDLE;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;
   assign rsp_tuser   = rsp_user_ff;
   assign status.idle = state_ff == ST_IDLE;

   always_comb begin
      logic [WIDE_W-1:0]  wide;
      logic [QUOT_W-1:0]  q;
      logic [SPEED_W-1:0] cur;
      logic [SPEED_W-1:0] tg;
      logic               neg;
      wide         = '0;
      q            = '0;
      cur          = '0;
      tg           = '0;
      neg          = 1'b0;
      state_in     = state_ff;
      head_in      = head_ff;
      lanes_in     = lanes_ff;
      prod_in      = prod_ff;
      dvd_in       = dvd_ff;
      quot_in      = quot_ff;
      ovf_in       = ovf_ff;
      vs_in        = vs_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               head_in  = q_head;
               lanes_in = q_lanes;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            for (int i = 0; i < WHEEL_COUNT; i++)
               prod_in[i] = PROD_W'(lanes_ff[i].mag) * PROD_W'(head_ff.mulb);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            for (int i = 0; i < WHEEL_COUNT; i++) begin
               wide      = WIDE_W'(prod_ff[i]) * WIDE_W'(head_ff.factor);
               dvd_in[i] = head_ff.over ? DVD_W'(prod_ff[i]) : DVD_W'(wide[WIDE_W-1:16]);
               quot_in[i] = '0;
            end
            vs_in    = {1'b0, head_ff.den, 15'b0};
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            for (int i = 0; i < WHEEL_COUNT; i++) begin
               // quotient too large for 16 bits: mark for saturation
               if (step_ff == '0) ovf_in[i] = dvd_ff[i] >= {head_ff.den, 16'b0};
               if (dvd_ff[i] >= vs_ff) begin
                  dvd_in[i]  = dvd_ff[i] - vs_ff;
                  quot_in[i] = {quot_ff[i][QUOT_W-2:0], 1'b1};
               end else begin
                  quot_in[i] = {quot_ff[i][QUOT_W-2:0], 1'b0};
               end
            end
            vs_in   = vs_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               for (int i = 0; i < WHEEL_COUNT; i++) begin
                  q   = quot_ff[i];
                  neg = lanes_ff[i].neg;
                  if (head_ff.over) begin
                     cur = '0;
                     tg  = head_ff.clip ? (neg ? SPEED_W'(-q) : q) : lanes_ff[i].target;
                  end else begin
                     tg = lanes_ff[i].target;
                     if (head_ff.zero) cur = '0;
                     else if (neg) cur = (ovf_ff[i] || q > SAT_NEG) ? SAT_NEG : SPEED_W'(-q);
                     else cur = (ovf_ff[i] || q > SAT_POS) ? SAT_POS : q;
                  end
                  rsp_data_in[i*SPEED_W +: SPEED_W]               = cur;
                  rsp_data_in[(WHEEL_COUNT+i)*SPEED_W +: SPEED_W] = tg;
               end
               rsp_user_in  = !head_ff.over;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff     <= head_in;
      lanes_ff    <= lanes_in;
      prod_ff     <= prod_in;
      dvd_ff      <= dvd_in;
      quot_ff     <= quot_in;
      ovf_ff      <= ovf_in;
      vs_ff       <= vs_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule
`default_nettype wire
